[design/sac_pkg.sv]
// Shared constants, codes and entry type for the stream admission controller.
package sac_pkg;
   localparam int unsigned TableEntriesDefault = 16;
   localparam logic [31:0] DefRecBytes  = 32'd4194304;
   localparam logic [31:0] DefLiveBytes = 32'd1048576;
   localparam logic [31:0] DefSlots     = 32'd4;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0, OP_RELEASE = 2'd1, OP_RELEASE_ALL = 2'd2, OP_RSVD = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_OK = 4'd0, ST_DUPLICATE = 4'd1, ST_LOCK = 4'd2, ST_STREAMS = 4'd3,
      ST_ENCODERS = 4'd4, ST_BYTES = 4'd5, ST_RELEASED = 4'd6, ST_UNKNOWN = 4'd7,
      ST_ALL_RELEASED = 4'd8
   } status_type;

   localparam logic [2:0] CSR_MAX_STREAMS  = 3'd0;
   localparam logic [2:0] CSR_MAX_ENCODERS = 3'd1;
   localparam logic [2:0] CSR_MAX_BYTES    = 3'd2;
   localparam logic [2:0] CSR_FORCE_MODEL  = 3'd3;
   localparam logic [2:0] CSR_ENF_MODEL    = 3'd4;

   typedef struct packed {
      logic [15:0] stream;
      logic        locked;
      logic [15:0] lock_id;
      logic [15:0] encoders;
      logic [63:0] bytes;
   } entry_type;
endpackage

[design/stream_admission_controller_top.sv]
// Top level: stream table memory, scan sequencer, budget checks and result register.
// An allocate or release reads every table entry in turn through the registered table memory,
//   then makes its decision; release-all and unknown operations go straight to the decision.
// One request at a time: the next is accepted once the result of the last is registered,
//   which a result stall can hold back.
// Reset: synchronous active high; clears entry valid bits, totals and registers to defaults.
module stream_admission_controller_top #(
   parameter int unsigned TABLE_ENTRIES = sac_pkg::TableEntriesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_stream_id,
   input  logic        req_has_lock,
   input  logic [15:0] req_lock_id,
   input  logic [15:0] req_encoder_need,
   input  logic [31:0] req_min_slot_bytes,
   input  logic [31:0] req_min_slots,
   input  logic        req_recording,
   input  logic [1:0]  req_wanted_model,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_echo_stream,
   output logic        rsp_granted,
   output logic [3:0]  rsp_status,
   output logic [31:0] rsp_ring_slots,
   output logic [31:0] rsp_ring_slot_bytes,
   output logic        rsp_drop_policy,
   output logic [1:0]  rsp_model_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   import sac_pkg::*;

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int SW = $clog2(TABLE_ENTRIES + 1);
   localparam int CW = ((SW > 5) ? SW : 5) + 1;
   localparam logic [CW-1:0] Depth = CW'(TABLE_ENTRIES);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DECIDE} state_type;

   state_type      state_ff;
   logic [IW:0]    cnt_ff;
   logic           rd_vld_ff;
   logic [IW-1:0]  rd_idx_ff;
   logic           dup_ff, lock_hit_ff, free_found_ff, hit_ff;
   logic [IW-1:0]  free_idx_ff, hit_idx_ff;
   logic [15:0]    hit_enc_ff;
   logic [63:0]    hit_bytes_ff;
   logic [63:0]    ring_ff;

   // captured request
   op_type         op_ff;
   logic [15:0]    sid_ff, lk_ff, need_ff;
   logic           has_lock_ff, rec_ff;
   logic [31:0]    size_ff, count_ff;
   logic [1:0]     wanted_ff;

   // configuration and totals
   logic [4:0]     max_streams_ff;
   logic [15:0]    max_enc_ff;
   logic [63:0]    max_bytes_ff;
   logic           force_ff;
   logic [1:0]     enf_model_ff;
   logic [SW-1:0]  stream_total_ff;
   logic [15:0]    enc_total_ff;
   logic [63:0]    byte_total_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff;

   // table memory
   entry_type      mem [TABLE_ENTRIES];
   entry_type      rd_data_ff;
   entry_type      wr_data;
   logic           wr_en;

   logic           req_accept, out_free;
   logic [CW-1:0]  limit, total_plus;
   logic [16:0]    enc_sum;
   logic [64:0]    byte_sum;
   status_type     dec_status;
   logic           dec_grant;

   assign csr_ready  = 1'b1;
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid || !rsp_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_streams_ff <= 5'd16;
         max_enc_ff     <= 16'hFFFF;
         max_bytes_ff   <= '1;
         force_ff       <= 1'b0;
         enf_model_ff   <= 2'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_STREAMS:  max_streams_ff <= csr_data[4:0];
            CSR_MAX_ENCODERS: max_enc_ff     <= csr_data[15:0];
            CSR_MAX_BYTES:    max_bytes_ff   <= csr_data;
            CSR_FORCE_MODEL:  force_ff       <= csr_data[0];
            CSR_ENF_MODEL:    enf_model_ff   <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // table memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[free_idx_ff] <= wr_data;
      rd_data_ff <= mem[cnt_ff[IW-1:0]];
   end

   // budget checks
   always_comb begin
      limit      = ({{(CW-5){1'b0}}, max_streams_ff} > Depth) ? Depth
                   : {{(CW-5){1'b0}}, max_streams_ff};
      total_plus = CW'(stream_total_ff) + CW'(1);
      enc_sum    = {1'b0, enc_total_ff} + {1'b0, need_ff};
      byte_sum   = {1'b0, byte_total_ff} + {1'b0, ring_ff};
      dec_grant  = 1'b0;
      if (dup_ff)                                     dec_status = ST_DUPLICATE;
      else if (has_lock_ff && lock_hit_ff)            dec_status = ST_LOCK;
      else if (total_plus > limit)                    dec_status = ST_STREAMS;
      else if (enc_sum > {1'b0, max_enc_ff})          dec_status = ST_ENCODERS;
      else if (byte_sum[64] || byte_sum[63:0] > max_bytes_ff) dec_status = ST_BYTES;
      else if (!free_found_ff)                        dec_status = ST_STREAMS;
      else begin
         dec_status = ST_OK;
         dec_grant  = 1'b1;
      end
      wr_data.stream   = sid_ff;
      wr_data.locked   = has_lock_ff;
      wr_data.lock_id  = has_lock_ff ? lk_ff : 16'd0;
      wr_data.encoders = need_ff;
      wr_data.bytes    = ring_ff;
      wr_en = (state_ff == S_DECIDE) && out_free && (op_ff == OP_ALLOC) && dec_grant;
   end

   // sequencer, scan evaluation, totals and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid       <= 1'b0;
         rd_vld_ff       <= 1'b0;
         valid_ff        <= '0;
         stream_total_ff <= '0;
         enc_total_ff    <= '0;
         byte_total_ff   <= '0;
      end else begin
         if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  op_ff       <= op_type'(req_operation);
                  sid_ff      <= req_stream_id;
                  has_lock_ff <= req_has_lock;
                  lk_ff       <= req_lock_id;
                  need_ff     <= req_encoder_need;
                  size_ff     <= (req_min_slot_bytes != 32'd0) ? req_min_slot_bytes
                                 : (req_recording ? DefRecBytes : DefLiveBytes);
                  count_ff    <= (req_min_slots != 32'd0) ? req_min_slots : DefSlots;
                  rec_ff      <= req_recording;
                  wanted_ff   <= req_wanted_model;
                  cnt_ff        <= '0;
                  rd_vld_ff     <= 1'b0;
                  dup_ff        <= 1'b0;
                  lock_hit_ff   <= 1'b0;
                  free_found_ff <= 1'b0;
                  hit_ff        <= 1'b0;
                  state_ff <= (req_operation == OP_ALLOC || req_operation == OP_RELEASE)
                              ? S_SCAN : S_DECIDE;
               end
            end
            S_SCAN: begin
               ring_ff <= 64'(count_ff) * 64'(size_ff);
               // issue one read per entry
               if (cnt_ff != (IW+1)'(TABLE_ENTRIES)) begin
                  rd_idx_ff <= cnt_ff[IW-1:0];
                  cnt_ff    <= cnt_ff + 1'b1;
                  rd_vld_ff <= 1'b1;
               end else begin
                  rd_vld_ff <= 1'b0;
                  if (!rd_vld_ff) state_ff <= S_DECIDE;
               end
               // compare returned entry
               if (rd_vld_ff) begin
                  if (valid_ff[rd_idx_ff]) begin
                     if (rd_data_ff.stream == sid_ff) begin
                        dup_ff <= 1'b1;
                        if (!hit_ff) begin
                           hit_ff       <= 1'b1;
                           hit_idx_ff   <= rd_idx_ff;
                           hit_enc_ff   <= rd_data_ff.encoders;
                           hit_bytes_ff <= rd_data_ff.bytes;
                        end
                     end
                     if (rd_data_ff.locked && rd_data_ff.lock_id == lk_ff)
                        lock_hit_ff <= 1'b1;
                  end else if (!free_found_ff) begin
                     free_found_ff <= 1'b1;
                     free_idx_ff   <= rd_idx_ff;
                  end
               end
            end
            S_DECIDE: begin
               if (out_free) begin
                  rsp_valid           <= 1'b1;
                  rsp_echo_stream     <= sid_ff;
                  rsp_granted         <= 1'b0;
                  rsp_ring_slots      <= '0;
                  rsp_ring_slot_bytes <= '0;
                  rsp_drop_policy     <= 1'b0;
                  rsp_model_out       <= 2'd0;
                  rsp_status          <= ST_UNKNOWN;
                  state_ff            <= S_IDLE;
                  unique case (op_ff)
                     OP_ALLOC: begin
                        rsp_status <= dec_status;
                        if (dec_grant) begin
                           valid_ff[free_idx_ff] <= 1'b1;
                           stream_total_ff <= stream_total_ff + 1'b1;
                           enc_total_ff    <= enc_sum[15:0];
                           byte_total_ff   <= byte_sum[63:0];
                           rsp_granted         <= 1'b1;
                           rsp_ring_slots      <= count_ff;
                           rsp_ring_slot_bytes <= size_ff;
                           rsp_drop_policy     <= rec_ff;
                           rsp_model_out       <= force_ff ? enf_model_ff : wanted_ff;
                        end
                     end
                     OP_RELEASE: begin
                        if (hit_ff) begin
                           valid_ff[hit_idx_ff] <= 1'b0;
                           stream_total_ff <= stream_total_ff - 1'b1;
                           enc_total_ff    <= enc_total_ff - hit_enc_ff;
                           byte_total_ff   <= byte_total_ff - hit_bytes_ff;
                           rsp_status      <= ST_RELEASED;
                        end
                     end
                     OP_RELEASE_ALL: begin
                        valid_ff        <= '0;
                        stream_total_ff <= '0;
                        enc_total_ff    <= '0;
                        byte_total_ff   <= '0;
                        rsp_status      <= ST_ALL_RELEASED;
                     end
                     default: ;
                  endcase
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // stream count matches the valid bits
   a_count: assert property (@(posedge clock) disable iff (reset)
      32'(stream_total_ff) == $countones(valid_ff))
      else $error("stream total differs from valid entries");
   // a grant always reports ok
   a_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted |-> rsp_status == ST_OK)
      else $error("grant without ok status");
   // an accepted request leaves idle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff != S_IDLE)
      else $error("request accepted but sequencer idle");
   // table writes only target a free entry
   a_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !valid_ff[free_idx_ff])
      else $error("write to occupied entry");
endmodule

[tb/sv/tb_stream_admission_controller_top.sv]
// Self-checking testbench for the stream admission controller: directed and random requests against a predictor.
`timescale 1ns / 100ps

module tb_stream_admission_controller_top;
   import sac_pkg::*;

   localparam int Depth = 16;

   typedef struct packed {
      op_type      op;
      logic [15:0] sid;
      logic        has_lock;
      logic [15:0] lock_id;
      logic [15:0] encoder_need;
      logic [31:0] min_slot_bytes;
      logic [31:0] min_slots;
      logic        recording;
      logic [1:0]  wanted_model;
   } request_word;

   typedef struct packed {
      logic [15:0] echo_stream;
      logic        granted;
      status_type  status;
      logic [31:0] ring_slots;
      logic [31:0] ring_slot_bytes;
      logic        drop_policy;
      logic [1:0]  model_out;
   } verdict_word;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = '0;
   logic [15:0] req_stream_id = '0;
   logic        req_has_lock = 1'b0;
   logic [15:0] req_lock_id = '0;
   logic [15:0] req_encoder_need = '0;
   logic [31:0] req_min_slot_bytes = '0;
   logic [31:0] req_min_slots = '0;
   logic        req_recording = 1'b0;
   logic [1:0]  req_wanted_model = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_echo_stream;
   logic        rsp_granted;
   logic [3:0]  rsp_status;
   logic [31:0] rsp_ring_slots;
   logic [31:0] rsp_ring_slot_bytes;
   logic        rsp_drop_policy;
   logic [1:0]  rsp_model_out;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   stream_admission_controller_top dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow of the admission table and limits
   logic        live_valid [Depth];
   logic [15:0] live_stream [Depth];
   logic        live_locked [Depth];
   logic [15:0] live_lock [Depth];
   logic [15:0] live_enc [Depth];
   logic [63:0] live_bytes [Depth];
   int unsigned stream_count;
   logic [16:0] encoder_sum;
   logic [63:0] byte_sum;
   logic [4:0]  lim_streams;
   logic [15:0] lim_encoders;
   logic [63:0] lim_bytes;
   logic        force_mdl;
   logic [1:0]  forced_mdl;

   // Queues fill at the front; the oldest word sits at the back
   request_word pending_words[$];
   verdict_word expected_verdicts[$];
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_cycles = 0;
   int          mismatches = 0;
   int          accepted = 0;

   function automatic void clear_admissions();
      for (int i = 0; i < Depth; i++) live_valid[i] = 1'b0;
      stream_count = 0;
      encoder_sum = '0;
      byte_sum = '0;
   endfunction

   function automatic verdict_word admit(request_word w);
      verdict_word v;
      logic [31:0] size, count;
      logic [63:0] ring;
      logic [64:0] total;
      int hit, free_slot;
      int unsigned cap;
      logic lock_busy;
      v = '0;
      v.echo_stream = w.sid;
      v.status = ST_UNKNOWN;
      hit = -1;
      free_slot = -1;
      lock_busy = 1'b0;
      for (int i = Depth - 1; i >= 0; i--) begin
         if (live_valid[i] && live_stream[i] == w.sid) hit = i;
         if (live_valid[i] && live_locked[i] && live_lock[i] == w.lock_id) lock_busy = 1'b1;
         if (!live_valid[i]) free_slot = i;
      end
      case (w.op)
         OP_ALLOC: begin
            cap = (lim_streams > Depth) ? Depth : lim_streams;
            size = (w.min_slot_bytes == 0) ? (w.recording ? DefRecBytes : DefLiveBytes)
                                           : w.min_slot_bytes;
            count = (w.min_slots == 0) ? DefSlots : w.min_slots;
            ring = 64'(count) * 64'(size);
            total = {1'b0, byte_sum} + {1'b0, ring};
            if (hit >= 0) v.status = ST_DUPLICATE;
            else if (w.has_lock && lock_busy) v.status = ST_LOCK;
            else if (stream_count + 1 > cap) v.status = ST_STREAMS;
            else if (encoder_sum + w.encoder_need > lim_encoders) v.status = ST_ENCODERS;
            else if (total[64] || total[63:0] > lim_bytes) v.status = ST_BYTES;
            else if (free_slot < 0) v.status = ST_STREAMS;
            else begin
               live_valid[free_slot] = 1'b1;
               live_stream[free_slot] = w.sid;
               live_locked[free_slot] = w.has_lock;
               live_lock[free_slot] = w.has_lock ? w.lock_id : 16'd0;
               live_enc[free_slot] = w.encoder_need;
               live_bytes[free_slot] = ring;
               stream_count++;
               encoder_sum += w.encoder_need;
               byte_sum = total[63:0];
               v.granted = 1'b1;
               v.status = ST_OK;
               v.ring_slots = count;
               v.ring_slot_bytes = size;
               v.drop_policy = w.recording;
               v.model_out = force_mdl ? forced_mdl : w.wanted_model;
            end
         end
         OP_RELEASE: begin
            if (hit >= 0) begin
               live_valid[hit] = 1'b0;
               stream_count--;
               encoder_sum -= live_enc[hit];
               byte_sum -= live_bytes[hit];
               v.status = ST_RELEASED;
            end
         end
         OP_RELEASE_ALL: begin
            clear_admissions();
            v.status = ST_ALL_RELEASED;
         end
         default: ;
      endcase
      return v;
   endfunction

   // Drive request words from the pending queue
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_verdicts.push_front(admit(pending_words.pop_back()));
         accepted++;
      end
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_stall) begin
         req_valid <= 1'b1;
      end else if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
         req_valid <= 1'b1;
         req_operation <= pending_words[$].op;
         req_stream_id <= pending_words[$].sid;
         req_has_lock <= pending_words[$].has_lock;
         req_lock_id <= pending_words[$].lock_id;
         req_encoder_need <= pending_words[$].encoder_need;
         req_min_slot_bytes <= pending_words[$].min_slot_bytes;
         req_min_slots <= pending_words[$].min_slots;
         req_recording <= pending_words[$].recording;
         req_wanted_model <= pending_words[$].wanted_model;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Stall the result side, with an optional long hold
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Check each result word against the oldest expectation
   always @(posedge clock) begin
      verdict_word got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_echo_stream, rsp_granted, status_type'(rsp_status), rsp_ring_slots,
                rsp_ring_slot_bytes, rsp_drop_policy, rsp_model_out};
         if (expected_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", got);
         end else begin
            want = expected_verdicts.pop_back();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MAX_STREAMS: lim_streams = value[4:0];
         CSR_MAX_ENCODERS: lim_encoders = value[15:0];
         CSR_MAX_BYTES: lim_bytes = value;
         CSR_FORCE_MODEL: force_mdl = value[0];
         CSR_ENF_MODEL: forced_mdl = value[1:0];
         default: ;
      endcase
   endtask

   task automatic queue_word(input op_type op, input logic [15:0] sid, input logic lk,
                             input logic [15:0] lid, input logic [15:0] enc,
                             input logic [31:0] sz, input logic [31:0] cnt,
                             input logic rec, input logic [1:0] mdl);
      request_word w;
      w = '{op, sid, lk, lid, enc, sz, cnt, rec, mdl};
      pending_words.push_front(w);
   endtask

   // Random word; mostly allocates and releases on a small id pool so streams collide
   task automatic queue_random();
      request_word w;
      int pick;
      w.op = op_type'($urandom_range(2, 0));
      pick = $urandom_range(99);
      if (pick < 55) w.op = OP_ALLOC;
      else if (pick < 90) w.op = OP_RELEASE;
      else if (pick < 96) w.op = OP_RELEASE_ALL;
      else if (pick < 98) w.op = OP_RSVD;
      w.sid = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(23));
      w.has_lock = 1'($urandom_range(1));
      w.lock_id = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(7));
      w.encoder_need = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(4000));
      w.min_slot_bytes = ($urandom_range(2) == 0) ? 32'd0
                       : ($urandom_range(4) == 0) ? 32'($urandom) : 32'($urandom_range(1 << 20));
      w.min_slots = ($urandom_range(2) == 0) ? 32'd0
                  : ($urandom_range(4) == 0) ? 32'($urandom) : 32'($urandom_range(64));
      w.recording = 1'($urandom_range(1));
      w.wanted_model = 2'($urandom_range(3));
      pending_words.push_front(w);
   endtask

   task automatic drain();
      while (pending_words.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (Depth + 8) @(posedge clock);
   endtask

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++) queue_random();
      drain();
   endtask

   initial begin
      lim_streams = 5'd16;
      lim_encoders = 16'hFFFF;
      lim_bytes = '1;
      force_mdl = 1'b0;
      forced_mdl = 2'd0;
      clear_admissions();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, every operation and every status but the byte budget
      send_idle_pct = 23;
      recv_idle_pct = 57;
      queue_word(OP_ALLOC, 16'h0000, 1'b1, 16'hFFFF, 16'd0, 32'd0, 32'd0, 1'b0, 2'd0);
      queue_word(OP_ALLOC, 16'h0000, 1'b0, 16'd0, 16'd1, 32'd8, 32'd2, 1'b1, 2'd3);
      queue_word(OP_ALLOC, 16'hFFFF, 1'b1, 16'hFFFF, 16'd1, 32'd0, 32'd0, 1'b1, 2'd1);
      queue_word(OP_ALLOC, 16'h1234, 1'b0, 16'hFFFF, 16'hFFFF, 32'd0, 32'd3, 1'b0, 2'd2);
      queue_word(OP_ALLOC, 16'h1235, 1'b0, 16'd0, 16'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 1'b1, 2'd3);
      queue_word(OP_ALLOC, 16'h1236, 1'b0, 16'd0, 16'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 1'b0, 2'd1);
      queue_word(OP_RELEASE, 16'h0000, 1'b0, 16'd0, 16'd0, 32'd0, 32'd0, 1'b0, 2'd0);
      queue_word(OP_RELEASE, 16'h0000, 1'b1, 16'hFFFF, 16'hFFFF, '1, '1, 1'b1, 2'd3);
      queue_word(OP_RSVD, 16'hABCD, 1'b1, 16'hFFFF, 16'hFFFF, '1, '1, 1'b1, 2'd3);
      queue_word(OP_RELEASE_ALL, 16'h5555, 1'b0, 16'd0, 16'd0, 32'd0, 32'd0, 1'b0, 2'd0);
      for (int i = 0; i < 17; i++)
         queue_word(OP_ALLOC, 16'(100 + i), 1'b0, 16'd0, 16'd1, 32'd1, 32'd1, 1'b0, 2'd2);
      queue_word(OP_RELEASE_ALL, 16'hAAAA, 1'b0, 16'd0, 16'd0, 32'd0, 32'd0, 1'b0, 2'd0);
      drain();

      // Long receiver hold while the sender keeps offering words
      hold_cycles = 600;
      random_phase(60);

      // Tight limits, forced model
      write_reg(CSR_MAX_STREAMS, 64'd3);
      write_reg(CSR_MAX_ENCODERS, 64'd5000);
      write_reg(CSR_MAX_BYTES, 64'd40_000_000);
      write_reg(CSR_FORCE_MODEL, 64'd1);
      write_reg(CSR_ENF_MODEL, 64'd2);
      random_phase(200);

      send_idle_pct = 57;
      recv_idle_pct = 23;
      write_reg(CSR_MAX_STREAMS, 64'd0);
      write_reg(CSR_MAX_ENCODERS, 64'd0);
      write_reg(CSR_MAX_BYTES, 64'd0);
      random_phase(60);

      write_reg(CSR_MAX_STREAMS, 64'd31);
      write_reg(CSR_MAX_ENCODERS, 64'hFFFF);
      write_reg(CSR_MAX_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CSR_ENF_MODEL, 64'd3);
      random_phase(200);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(CSR_FORCE_MODEL, 64'd0);
      write_reg(CSR_MAX_STREAMS, 64'd16);
      write_reg(CSR_MAX_BYTES, 64'd200_000_000);
      random_phase(280);

      if (mismatches == 0 && expected_verdicts.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Give up after a generous fixed time
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

[filelist.f]
design/sac_pkg.sv
design/stream_admission_controller_top.sv
tb/sv/tb_stream_admission_controller_top.sv
